// ===== rtl/sqr_pkg.sv =====
// shared types and codes for the sequenced slot ring queue
// no dependencies; used by every module in rtl
package sqr_pkg;

	// parameter defaults
	localparam int SLOTS_LOG2_DEF    = 6;
	localparam int PAYLOAD_WIDTH_DEF = 64;

	// widest capacity the 3-bit register can ask for
	localparam int CAP_LOG2_MAX = 7;

	// command codes
	localparam logic [2:0] CMD_CLAIM_WR  = 3'd0;
	localparam logic [2:0] CMD_COMMIT_WR = 3'd1;
	localparam logic [2:0] CMD_CLAIM_RD  = 3'd2;
	localparam logic [2:0] CMD_COMMIT_RD = 3'd3;
	localparam logic [2:0] CMD_QUERY     = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_PENDING = 3'd3;
	localparam logic [2:0] ST_BADCMD  = 3'd4;

	// register index
	localparam logic REG_CAPACITY_LOG2 = 1'b0;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] position;
		logic [63:0] data_in;
	} cmd_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] position_out;
		logic [5:0]  slot_index;
		logic [63:0] data_out;
		logic [6:0]  occupancy;
		logic        is_empty;
	} res_req_t;

	// slot write request from the execute logic to the slot store
	typedef struct packed {
		logic        seq_en;
		logic        data_en;
		logic [63:0] seq;
		logic [63:0] data;
	} slot_wr_t;

endpackage

// ===== rtl/sqr_slot_store.sv =====
// slot sequence and payload memories with valid bits and write forwarding
// depends on sqr_pkg
module sqr_slot_store #(
	parameter int IDXW = 6,
	parameter int PW   = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  rd_en,
	input  logic [IDXW-1:0]       raddr,
	input  logic [IDXW-1:0]       widx,
	input  sqr_pkg::slot_wr_t     wr,
	output logic [63:0]           rd_seq,
	output logic [63:0]           rd_data
);
	localparam int DEPTH = 1 << IDXW;

	logic [63:0]     seq_mem [DEPTH];
	logic [PW-1:0]   pay_mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	logic [63:0]     seq_raw_s1;
	logic [PW-1:0]   pay_raw_s1;
	logic [IDXW-1:0] idx_s1;
	logic            hit_seq_s1;
	logic            hit_pay_s1;
	logic [63:0]     fwd_seq_s1;
	logic [PW-1:0]   fwd_pay_s1;
	logic            valid_s1;

	always_ff @(posedge clk) begin
		if (wr.seq_en) begin
			seq_mem[widx] <= wr.seq;
		end
		if (wr.data_en) begin
			pay_mem[widx] <= wr.data[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			seq_raw_s1 <= seq_mem[raddr];
			pay_raw_s1 <= pay_mem[raddr];
			idx_s1     <= raddr;
			fwd_seq_s1 <= wr.seq;
			fwd_pay_s1 <= wr.data[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_s1   <= 1'b0;
			hit_seq_s1 <= 1'b0;
			hit_pay_s1 <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr.seq_en) begin
				valid_q[widx] <= 1'b1;
			end
			if (rd_en) begin
				valid_s1   <= valid_q[raddr];
				hit_seq_s1 <= wr.seq_en && (widx == raddr);
				hit_pay_s1 <= wr.data_en && (widx == raddr);
			end
		end
	end

	// never-written sequence entries read as their slot number
	assign rd_seq  = hit_seq_s1 ? fwd_seq_s1 :
		(valid_s1 ? seq_raw_s1 : 64'(idx_s1));
	assign rd_data = 64'(hit_pay_s1 ? fwd_pay_s1 : pay_raw_s1);

endmodule

// ===== rtl/sqr_exec.sv =====
// command execution: claim and commit decisions, counter updates, result fields
// depends on sqr_pkg
module sqr_exec #(
	parameter int IDXW = 6
) (
	input  sqr_pkg::cmd_req_t  item,
	input  logic [63:0]        seq,
	input  logic [63:0]        data,
	input  logic [63:0]        pc,
	input  logic [63:0]        cc,
	input  logic [2:0]         cap_log2,
	input  logic [IDXW-1:0]    mask,
	output sqr_pkg::res_req_t  res,
	output logic [63:0]        pc_nxt,
	output logic [63:0]        cc_nxt,
	output logic [IDXW-1:0]    widx,
	output sqr_pkg::slot_wr_t  wr
);
	logic [63:0]     cap64;
	logic [63:0]     diff;
	logic [63:0]     want;
	logic [IDXW-1:0] idx;
	logic [IDXW+5:0] idx_ext;
	logic [6:0]      occ;

	assign cap64 = 64'd1 << cap_log2;
	assign diff  = pc - cc;
	assign want  = cc + 64'd1;

	always_comb begin
		res          = '0;
		res.status   = sqr_pkg::ST_OK;
		pc_nxt       = pc;
		cc_nxt       = cc;
		idx          = '0;
		wr.seq_en    = 1'b0;
		wr.data_en   = 1'b0;
		wr.seq       = item.position;
		wr.data      = item.data_in;
		case (item.command)
			sqr_pkg::CMD_CLAIM_WR: begin
				idx = pc[IDXW-1:0] & mask;
				if (seq == pc) begin
					pc_nxt           = pc + 64'd1;
					res.position_out = pc;
				end else if (!diff[63] && (diff >= cap64)) begin
					res.status = sqr_pkg::ST_FULL;
				end else begin
					res.status = sqr_pkg::ST_PENDING;
				end
			end
			sqr_pkg::CMD_COMMIT_WR: begin
				idx              = item.position[IDXW-1:0] & mask;
				wr.seq_en        = 1'b1;
				wr.data_en       = 1'b1;
				wr.seq           = item.position + 64'd1;
				res.position_out = item.position;
			end
			sqr_pkg::CMD_CLAIM_RD: begin
				idx = cc[IDXW-1:0] & mask;
				if (seq == want) begin
					cc_nxt           = want;
					res.position_out = cc + cap64;
					res.data_out     = data;
				end else if ((seq < want) && (cc == pc)) begin
					res.status = sqr_pkg::ST_EMPTY;
				end else begin
					res.status = sqr_pkg::ST_PENDING;
				end
			end
			sqr_pkg::CMD_COMMIT_RD: begin
				idx              = item.position[IDXW-1:0] & mask;
				wr.seq_en        = 1'b1;
				res.position_out = item.position;
			end
			sqr_pkg::CMD_QUERY: begin
			end
			default: begin
				res.status = sqr_pkg::ST_BADCMD;
			end
		endcase
		res.slot_index = idx_ext[5:0];
		res.occupancy  = occ;
		res.is_empty   = (pc_nxt == cc_nxt);
	end

	assign idx_ext = {6'b0, idx};
	assign occ     = pc_nxt[6:0] - cc_nxt[6:0];
	assign widx    = idx;

endmodule

// ===== rtl/sequenced_slot_ring_queue_core.sv =====
// top level of the sequenced slot ring queue: config register, counters, pipeline control
// depends on sqr_pkg, sqr_slot_store, sqr_exec
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  cmd      | in        | cmd_valid/cmd_stall | sqr_pkg::cmd_req_t
//  res      | out       | res_valid/res_stall | sqr_pkg::res_req_t
//  apb      | in        | psel/penable/pready | capacity_log2 at byte address 0
//
// one request per cycle while results do not stall; the slot memory is read at accept,
// stage 1 makes the decision and counter update, and the result register holds its result
// the read address for each request is formed from the counters as the request
// ahead of it leaves them, and a same-slot write is forwarded into the read
// reset and every capacity write clear the counters and the slot valid bits at
// once; slots never written read back their own number, no clearing pass
// a stalled result holds in the result register while stage 1 holds one more request
module sequenced_slot_ring_queue_core #(
	parameter int SLOTS_LOG2    = sqr_pkg::SLOTS_LOG2_DEF,
	parameter int PAYLOAD_WIDTH = sqr_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  sqr_pkg::cmd_req_t cmd,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output sqr_pkg::res_req_t res,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	// only slots below the largest capacity the register can select are reachable
	localparam int IDXW = (SLOTS_LOG2 > sqr_pkg::CAP_LOG2_MAX) ?
		sqr_pkg::CAP_LOG2_MAX : SLOTS_LOG2;
	localparam logic [4:0] CAP_LIM = 5'(SLOTS_LOG2 > sqr_pkg::CAP_LOG2_MAX ?
		sqr_pkg::CAP_LOG2_MAX : SLOTS_LOG2);
	localparam logic [2:0] CAP_RST = 3'(SLOTS_LOG2 > 6 ? 6 : SLOTS_LOG2);

	// configuration state
	logic [2:0]  cap_q;
	logic        cfg_we;
	logic        reg_idx;
	logic [2:0]  cfg_v;
	logic [2:0]  cfg_sat;

	// queue counters
	logic [63:0] pc_q;
	logic [63:0] cc_q;

	// stage 1 and result register
	logic              valid_s1;
	sqr_pkg::cmd_req_t cmd_s1;
	logic              res_valid_s2;
	sqr_pkg::res_req_t res_s2;

	logic        accept;
	logic        s1_adv;
	logic        s1_fire;

	// exec outputs
	sqr_pkg::res_req_t ex_res;
	logic [63:0]       ex_pc_nxt;
	logic [63:0]       ex_cc_nxt;
	logic [IDXW-1:0]   ex_widx;
	sqr_pkg::slot_wr_t ex_wr;
	sqr_pkg::slot_wr_t st_wr;

	// slot store read side
	logic [63:0]     st_seq;
	logic [63:0]     st_data;
	logic [IDXW-1:0] mask;
	logic [IDXW-1:0] raddr;
	logic [63:0]     pc_sel;
	logic [63:0]     cc_sel;

	// apb: one register, reads combinational, always ready
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_we  = psel && penable && pwrite && pready &&
		(reg_idx == sqr_pkg::REG_CAPACITY_LOG2);
	assign cfg_v   = pwdata[2:0];
	// saturate to the slot count built in
	assign cfg_sat = ({2'b0, cfg_v} > CAP_LIM) ? CAP_LIM[2:0] : cfg_v;
	assign prdata  = (reg_idx == sqr_pkg::REG_CAPACITY_LOG2) ? {29'b0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
		end else if (cfg_we) begin
			cap_q <= cfg_sat;
		end
	end

	assign mask = IDXW'((8'd1 << cap_q) - 8'd1);

	// pipeline control: stage 1 moves when the result register is free or drains
	assign s1_adv    = !res_valid_s2 || !res_stall;
	assign s1_fire   = valid_s1 && s1_adv;
	assign cmd_stall = valid_s1 && !s1_adv;
	assign accept    = cmd_valid && !cmd_stall;

	// counters as the request in stage 1 leaves them
	assign pc_sel = s1_fire ? ex_pc_nxt : pc_q;
	assign cc_sel = s1_fire ? ex_cc_nxt : cc_q;

	// slot address for the incoming request
	always_comb begin
		case (cmd.command) inside
			sqr_pkg::CMD_CLAIM_WR:  raddr = pc_sel[IDXW-1:0] & mask;
			sqr_pkg::CMD_CLAIM_RD:  raddr = cc_sel[IDXW-1:0] & mask;
			sqr_pkg::CMD_COMMIT_WR,
			sqr_pkg::CMD_COMMIT_RD: raddr = cmd.position[IDXW-1:0] & mask;
			default:                raddr = '0;
		endcase
	end

	// slot writes happen only when the stage 1 request completes
	always_comb begin
		st_wr         = ex_wr;
		st_wr.seq_en  = ex_wr.seq_en && s1_fire;
		st_wr.data_en = ex_wr.data_en && s1_fire;
	end

	sqr_slot_store #(
		.IDXW (IDXW),
		.PW   (PAYLOAD_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_we),
		.rd_en   (accept),
		.raddr   (raddr),
		.widx    (ex_widx),
		.wr      (st_wr),
		.rd_seq  (st_seq),
		.rd_data (st_data)
	);

	sqr_exec #(
		.IDXW (IDXW)
	) u_exec (
		.item     (cmd_s1),
		.seq      (st_seq),
		.data     (st_data),
		.pc       (pc_q),
		.cc       (cc_q),
		.cap_log2 (cap_q),
		.mask     (mask),
		.res      (ex_res),
		.pc_nxt   (ex_pc_nxt),
		.cc_nxt   (ex_cc_nxt),
		.widx     (ex_widx),
		.wr       (ex_wr)
	);

	// counters: a capacity write reseeds; write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			cc_q <= '0;
		end else if (cfg_we) begin
			pc_q <= '0;
			cc_q <= '0;
		end else if (s1_fire) begin
			pc_q <= ex_pc_nxt;
			cc_q <= ex_cc_nxt;
		end
	end

	// stage 1 request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_fire) begin
			res_valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_s2 <= ex_res;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	// a result only shows up after stage 1 hands one over
	a_res_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_s2) |-> $past(s1_fire))
		else $error("result appeared without a stage 1 completion");

	// the producer count steps by one or is reseeded
	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pc_q) |-> (pc_q == $past(pc_q) + 64'd1) || $past(cfg_we))
		else $error("producer count jumped");

	// the consumer count steps by one or is reseeded
	a_cc_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cc_q) |-> (cc_q == $past(cc_q) + 64'd1) || $past(cfg_we))
		else $error("consumer count jumped");

	// a capacity write leaves both counters at zero
	a_cfg_reseed: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (pc_q == 64'd0) && (cc_q == 64'd0))
		else $error("counters not reseeded by capacity write");

endmodule

// ===== tb/sqr_ring_checker.sv =====
// result checker for the sequenced slot ring queue: watches the request, result and apb traffic
// keeps its own copy of counters and slots, predicts every result and compares it field by field
// depends on sqr_pkg
module sqr_ring_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  sqr_pkg::cmd_req_t cmd,
	input  logic              res_valid,
	input  logic              res_stall,
	input  sqr_pkg::res_req_t res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                backlog,
	output int                fail_count,
	output int                checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] DATA_MASK = (sqr_pkg::PAYLOAD_WIDTH_DEF >= 64) ? '1 :
		((64'd1 << (sqr_pkg::PAYLOAD_WIDTH_DEF % 64)) - 64'd1);

	logic [63:0] prod_cnt;
	logic [63:0] cons_cnt;
	logic [63:0] seq_mem [64];
	logic [63:0] data_mem [64];
	int          cap_log2;

	sqr_pkg::res_req_t answers_due [$];
	sqr_pkg::res_req_t want;
	int          fails;
	int          n_checked;

	task automatic reseed_slots();
		prod_cnt = '0;
		cons_cnt = '0;
		for (int i = 0; i < 64; i++) seq_mem[i] = 64'(i);
	endtask

	// one command against the ring copy: updates it and returns the answer
	function automatic sqr_pkg::res_req_t ring_answer(input sqr_pkg::cmd_req_t rq);
		sqr_pkg::res_req_t r;
		logic [63:0] cap;
		logic [63:0] mask;
		logic [63:0] diff;
		logic [63:0] want_seq;
		logic [5:0]  idx;
		r = '0;
		r.status = sqr_pkg::ST_OK;
		cap = 64'd1 << cap_log2;
		mask = cap - 64'd1;
		case (rq.command)
			sqr_pkg::CMD_CLAIM_WR: begin
				idx = 6'(prod_cnt & mask);
				r.slot_index = idx;
				if (seq_mem[idx] == prod_cnt) begin
					r.position_out = prod_cnt;
					prod_cnt = prod_cnt + 64'd1;
				end else begin
					// signed distance: a consumer ahead of the producer is never full
					diff = prod_cnt - cons_cnt;
					r.status = (!diff[63] && diff >= cap) ? sqr_pkg::ST_FULL :
						sqr_pkg::ST_PENDING;
				end
			end
			sqr_pkg::CMD_COMMIT_WR: begin
				idx = 6'(rq.position & mask);
				r.slot_index = idx;
				seq_mem[idx] = rq.position + 64'd1;
				data_mem[idx] = rq.data_in & DATA_MASK;
				r.position_out = rq.position;
			end
			sqr_pkg::CMD_CLAIM_RD: begin
				idx = 6'(cons_cnt & mask);
				r.slot_index = idx;
				want_seq = cons_cnt + 64'd1;
				if (seq_mem[idx] == want_seq) begin
					r.position_out = cons_cnt + cap;
					r.data_out = data_mem[idx];
					cons_cnt = want_seq;
				end else if (seq_mem[idx] < want_seq && cons_cnt == prod_cnt) begin
					r.status = sqr_pkg::ST_EMPTY;
				end else begin
					r.status = sqr_pkg::ST_PENDING;
				end
			end
			sqr_pkg::CMD_COMMIT_RD: begin
				idx = 6'(rq.position & mask);
				r.slot_index = idx;
				seq_mem[idx] = rq.position;
				r.position_out = rq.position;
			end
			sqr_pkg::CMD_QUERY: ;
			default: r.status = sqr_pkg::ST_BADCMD;
		endcase
		diff = prod_cnt - cons_cnt;
		r.occupancy = diff[6:0];
		r.is_empty = (diff == '0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answers_due.delete();
			cap_log2 = sqr_pkg::SLOTS_LOG2_DEF;
			for (int i = 0; i < 64; i++) data_mem[i] = '0;
			reseed_slots();
			fails = 0;
			n_checked = 0;
			backlog <= 0;
			fail_count <= 0;
			checked <= 0;
		end else begin
			// a result never belongs to a request taken at the same edge
			if (res_valid && !res_stall) begin
				if (answers_due.size() == 0) begin
					$error("result with no request outstanding: status %0d", res.status);
					fails++;
				end else begin
					want = answers_due.pop_front();
					n_checked++;
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						fails++;
					end
					if (res.position_out !== want.position_out) begin
						$error("position_out: expected %0h, got %0h",
							want.position_out, res.position_out);
						fails++;
					end
					if (res.slot_index !== want.slot_index) begin
						$error("slot_index: expected %0d, got %0d",
							want.slot_index, res.slot_index);
						fails++;
					end
					if (res.data_out !== want.data_out) begin
						$error("data_out: expected %0h, got %0h", want.data_out, res.data_out);
						fails++;
					end
					if (res.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, res.occupancy);
						fails++;
					end
					if (res.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, res.is_empty);
						fails++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) answers_due.push_back(ring_answer(cmd));
			if (psel && penable && pwrite && pready &&
				paddr[2] == sqr_pkg::REG_CAPACITY_LOG2) begin
				cap_log2 = (int'(pwdata[2:0]) > sqr_pkg::SLOTS_LOG2_DEF) ?
					sqr_pkg::SLOTS_LOG2_DEF : int'(pwdata[2:0]);
				reseed_slots();
			end
			backlog <= answers_due.size();
			fail_count <= fails;
			checked <= n_checked;
		end
	end

endmodule

// ===== tb/sequenced_slot_ring_queue_core_test.sv =====
// top of the ring queue testbench: clock, reset, request and apb stimulus, result back-pressure
// instantiates sequenced_slot_ring_queue_core and sqr_ring_checker; depends on sqr_pkg
module sequenced_slot_ring_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// first code past the defined commands, the block must answer bad command
	localparam logic [2:0] CMD_FIRST_BAD = 3'd5;
	localparam int         LONG_HOLD     = 80;
	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         N_PHASES      = 10;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	sqr_pkg::cmd_req_t cmd;
	logic        res_valid;
	logic        res_stall;
	sqr_pkg::res_req_t res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          backlog;
	int          fail_count;
	int          checked;

	// idle mix, sender side read only by the main process
	int          send_idle_pct;
	int          recv_idle_pct;
	// toggled once to ask the result side for a long hold-off
	logic        hold_req;
	logic        hold_seen;

	int unsigned cycle_no;
	int          n_sent;

	// stimulus view of the ring, valid only while the traffic is well formed
	logic [63:0] sh_prod;
	logic [63:0] sh_cons;
	logic [63:0] sh_cap;
	logic [63:0] open_wr [$];
	logic [63:0] open_rd [$];

	sequenced_slot_ring_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	sqr_ring_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.backlog    (backlog),
		.fail_count (fail_count),
		.checked    (checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial cycle_no = 0;
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == CYCLE_LIMIT) begin
			$display("FAIL sequenced_slot_ring_queue_core");
			$finish;
		end
	end

	// result side: random stall, plus one long hold-off on request
	initial begin
		res_stall = 1'b0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				// stall the results long enough for the block to back up into cmd_stall
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	function automatic sqr_pkg::cmd_req_t mk_req(input logic [2:0] c, input logic [63:0] p,
		input logic [63:0] d);
		sqr_pkg::cmd_req_t rq;
		rq.command = c;
		rq.position = p;
		rq.data_in = d;
		return rq;
	endfunction

	function automatic bit in_list(input logic [63:0] lst [$], input logic [63:0] v);
		foreach (lst[i]) if (lst[i] == v) return 1'b1;
		return 1'b0;
	endfunction

	// offer one request, after a random gap, and hold it until taken
	task automatic send_req(input sqr_pkg::cmd_req_t rq);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= rq;
		do @(posedge clk); while (cmd_stall);
		n_sent++;
	endtask

	// stop offering and wait until every result has come back
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write of the capacity register: setup then access phase
	task automatic write_capacity(input logic [2:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sqr_pkg::REG_CAPACITY_LOG2, 2'b00};
		pwdata <= {29'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one capacity setting: mostly claim/commit flows, the tail random and broken
	task automatic run_phase(input logic [2:0] cap_wr, input int n_items, input int wr_bias,
		input int hold_at);
		sqr_pkg::cmd_req_t rq;
		int       pick;
		int       k;
		int       j;
		int       n_broken;
		drain();
		write_capacity(cap_wr);
		sh_cap = 64'd1 << ((cap_wr > 3'(sqr_pkg::SLOTS_LOG2_DEF)) ?
			sqr_pkg::SLOTS_LOG2_DEF : int'(cap_wr));
		sh_prod = '0;
		sh_cons = '0;
		open_wr.delete();
		open_rd.delete();
		n_broken = n_items / 6;
		for (k = 0; k < n_items; k++) begin
			if (k == hold_at) hold_req <= ~hold_req;
			rq = mk_req(sqr_pkg::CMD_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
			pick = $urandom_range(0, 99);
			if (k >= n_items - n_broken) begin
				// broken tail: any code, positions near the live counters or anywhere
				rq.command = 3'($urandom_range(0, 7));
				case ($urandom_range(0, 2))
					0: rq.position = sh_prod - 64'($urandom_range(0, 2));
					1: rq.position = sh_cons + sh_cap - 64'($urandom_range(0, 2));
					default: ;
				endcase
			end else if (pick < 4) begin
				rq.command = CMD_FIRST_BAD + 3'($urandom_range(0, 2));
			end else if (pick < 8) begin
				rq.command = sqr_pkg::CMD_QUERY;
			end else if (pick < 30 && open_wr.size() != 0) begin
				j = $urandom_range(0, open_wr.size() - 1);
				rq.command = sqr_pkg::CMD_COMMIT_WR;
				rq.position = open_wr[j];
				open_wr.delete(j);
			end else if (pick < 52 && open_rd.size() != 0) begin
				j = $urandom_range(0, open_rd.size() - 1);
				rq.command = sqr_pkg::CMD_COMMIT_RD;
				rq.position = open_rd[j];
				open_rd.delete(j);
			end else if ($urandom_range(0, 99) < wr_bias) begin
				rq.command = sqr_pkg::CMD_CLAIM_WR;
				// succeeds unless full or the slot's read is still uncommitted
				if (sh_prod - sh_cons < sh_cap && !in_list(open_rd, sh_prod)) begin
					open_wr.push_back(sh_prod);
					sh_prod = sh_prod + 64'd1;
				end
			end else begin
				rq.command = sqr_pkg::CMD_CLAIM_RD;
				// succeeds once the slot at the consumer count is committed
				if (sh_cons < sh_prod && !in_list(open_wr, sh_cons)) begin
					open_rd.push_back(sh_cons + sh_cap);
					sh_cons = sh_cons + 64'd1;
				end
			end
			send_req(rq);
		end
	endtask

	logic [2:0] phase_cap [N_PHASES] = '{3'd0, 3'd2, 3'd6, 3'd7, 3'd1, 3'd3, 3'd4, 3'd5,
		3'd6, 3'd0};
	int phase_len [N_PHASES] = '{60, 60, 50, 50, 50, 50, 40, 40, 130, 20};
	int phase_bias [N_PHASES] = '{50, 65, 45, 30, 55, 60, 50, 70, 95, 50};

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		send_idle_pct = 26;
		recv_idle_pct = 54;
		n_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner cases at the reset capacity of 64 slots
		send_req(mk_req(sqr_pkg::CMD_QUERY, '0, '0));
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '0, '0));           // empty ring
		send_req(mk_req(sqr_pkg::CMD_CLAIM_WR, '1, '1));           // position 0
		send_req(mk_req(sqr_pkg::CMD_CLAIM_WR, '0, '0));           // position 1
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '0, '0));           // claimed, not committed
		send_req(mk_req(sqr_pkg::CMD_COMMIT_WR, 64'd0, '1));
		send_req(mk_req(sqr_pkg::CMD_COMMIT_WR, 64'd1, '0));
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '1, '0));           // all-ones payload
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '0, '1));           // zero payload
		send_req(mk_req(sqr_pkg::CMD_COMMIT_RD, 64'd64, '0));
		send_req(mk_req(sqr_pkg::CMD_COMMIT_RD, 64'd65, '0));
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '0, '0));           // empty again
		send_req(mk_req(CMD_FIRST_BAD, '1, '1));
		send_req(mk_req(CMD_FIRST_BAD + 3'd1, '0, '1));
		send_req(mk_req(CMD_FIRST_BAD + 3'd2, '1, '0));
		// commit ahead of the producer, so the consumer overtakes it
		send_req(mk_req(sqr_pkg::CMD_COMMIT_WR, 64'd2, 64'h5555_5555_5555_5555));
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '0, '0));
		send_req(mk_req(sqr_pkg::CMD_CLAIM_WR, '0, '0));           // negative distance, not full
		send_req(mk_req(sqr_pkg::CMD_COMMIT_RD, '1, '0));          // top position
		// sequence wraps to 0
		send_req(mk_req(sqr_pkg::CMD_COMMIT_WR, '1, 64'hAAAA_AAAA_AAAA_AAAA));
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '0, '0));           // sequence below wanted
		send_req(mk_req(sqr_pkg::CMD_COMMIT_RD, 64'd67, '0));
		send_req(mk_req(sqr_pkg::CMD_CLAIM_RD, '0, '0));           // sequence above wanted
		send_req(mk_req(sqr_pkg::CMD_QUERY, '1, '1));

		// random phases over every capacity setting, three idle mixes
		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 3) begin
				send_idle_pct = 54;
				recv_idle_pct <= 26;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			// the big full-ring phase gets the long result hold-off
			run_phase(phase_cap[p], phase_len[p], phase_bias[p], (p == 8) ? 40 : -1);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d requests: corner cases at reset, then %0d capacity settings",
			n_sent, N_PHASES);
		$display("from one slot to the saturated full ring; %0d results compared, %0d mismatches",
			checked, fail_count);
		if (fail_count == 0 && backlog == 0) begin
			$display("PASS sequenced_slot_ring_queue_core");
		end else begin
			$display("FAIL sequenced_slot_ring_queue_core");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sqr_pkg.sv
rtl/sqr_slot_store.sv
rtl/sqr_exec.sv
rtl/sequenced_slot_ring_queue_core.sv
tb/sqr_ring_checker.sv
tb/sequenced_slot_ring_queue_core_test.sv
